// ----- rtl/core/placement_density_bin_accumulator_core_defines.svh -----
// Assertion macros shared by the density bin accumulator RTL
`ifndef PLACEMENT_DENSITY_BIN_ACCUMULATOR_CORE_DEFINES_SVH
`define PLACEMENT_DENSITY_BIN_ACCUMULATOR_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define PDBA_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pdba: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define PDBA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pdba: next-cycle check failed");

`endif

// ----- rtl/core/pdba_pkg.sv -----
// Shared types, constants and helper functions of the density bin accumulator
`default_nettype none

package pdba_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_BINS_ACROSS = 3'd0;
    localparam logic [2:0] REG_BINS_DOWN   = 3'd1;
    localparam logic [2:0] REG_BIN_WIDTH   = 3'd2;
    localparam logic [2:0] REG_BIN_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_CORE_LEFT   = 3'd4;
    localparam logic [2:0] REG_CORE_BOTTOM = 3'd5;

    localparam int DVD_W  = 66;
    localparam int DVS_W  = 40;
    localparam int STEP_W = 7;
    localparam int CRD_W  = 40;

    localparam logic [STEP_W-1:0] STEPS_GEOM = 7'd34;
    localparam logic [STEP_W-1:0] STEPS_READ = 7'd66;

    localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [40:0] CAP41 = 41'h1FF_FFFF_FFFF;
    localparam logic [31:0] CAP32 = 32'hFFFF_FFFF;

    // Divider request from the sequencer
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    // Overlap length of two intervals, zero when disjoint
    function automatic logic [23:0] overlap(
        input logic signed [CRD_W-1:0] cl,
        input logic signed [CRD_W-1:0] cu,
        input logic signed [CRD_W-1:0] bl,
        input logic signed [CRD_W-1:0] bu
    );
        logic signed [CRD_W-1:0] hi;
        logic signed [CRD_W-1:0] lo;
        logic signed [CRD_W-1:0] diff;
        hi   = (cu < bu) ? cu : bu;
        lo   = (cl > bl) ? cl : bl;
        diff = hi - lo;
        if (cu <= bl || cl >= bu)
            return 24'd0;
        return diff[23:0];
    endfunction

    // Saturating 48-bit add
    function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? CAP48 : s[47:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pdba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
`default_nettype none

module pdba_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 65536
) (
    input  wire                                     clk,
    input  wire                                     we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                        wdata,
    input  wire                                     re,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pdba_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle
`default_nettype none

module pdba_div (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire  pdba_pkg::div_req_t        req,
    input  wire  [pdba_pkg::DVD_W-1:0]      dividend,
    input  wire  [pdba_pkg::DVS_W-1:0]      divisor,
    output logic                            done,
    output logic [pdba_pkg::DVD_W-1:0]      quotient,
    output logic [pdba_pkg::DVS_W-1:0]      remainder
);

    logic                             busy_reg;
    logic [pdba_pkg::STEP_W-1:0]      cnt_reg;
    logic                             done_reg;
    logic [pdba_pkg::DVD_W-1:0]       dq_reg;
    logic [pdba_pkg::DVS_W-1:0]       rem_reg;
    logic [pdba_pkg::DVS_W-1:0]       dvs_reg;
    logic [pdba_pkg::DVS_W:0]         rem_sh;
    logic [pdba_pkg::DVS_W:0]         rem_sub;
    logic                             ge;

    // Shift in one dividend bit, subtract when it fits
    assign rem_sh  = {rem_reg, dq_reg[pdba_pkg::DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Control: step count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pdba_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[pdba_pkg::DVS_W-1:0] : rem_sh[pdba_pkg::DVS_W-1:0];
            dq_reg  <= {dq_reg[pdba_pkg::DVD_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/placement_density_bin_accumulator_core.sv -----
// Density bin accumulator top level: command sequencer, bin memories, divider
// Load: parameter RAM write on acceptance; read: RAM read, 66-step divide, output.
// Add cell: up to 4 bin-bound divides, then for each covered bin
// (RAM read, 24x24 area multiply, 5 passes of the 48x8 partial-product multiplier, write).
// Clear: one accumulator RAM entry per cycle over all BIN_COUNT entries; one item at a time.
// Reset: async active low; runs the same clearing pass over all entries before in_ready rises.
`default_nettype none

module placement_density_bin_accumulator_core #(
    parameter int MAX_BINS_X = 256,
    parameter int MAX_BINS_Y = 256,
    parameter int BIN_COUNT  = 65536
) (
    input  wire                clk,
    input  wire                rst_n,
    // Configuration port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [4:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input words
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [1:0]         command,
    input  wire  [15:0]        bin_index,
    input  wire  [39:0]        blocked_area,
    input  wire  [39:0]        capacity_area,
    input  wire  [15:0]        target_density,
    input  wire  signed [31:0] center_x,
    input  wire  signed [31:0] center_y,
    input  wire  [23:0]        cell_width,
    input  wire  [23:0]        cell_height,
    input  wire  [23:0]        density_scale,
    input  wire                is_filler,
    input  wire                is_macro,
    // Result words
    output logic               out_valid,
    input  wire                out_ready,
    output logic [31:0]        bin_density,
    output logic [40:0]        overflow_area,
    output logic [47:0]        overflow_total
);

    localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int XW = $clog2(MAX_BINS_X + 1);
    localparam int YW = $clog2(MAX_BINS_Y + 1);
    localparam int IW = 26;
    localparam int CW = pdba_pkg::CRD_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PREP, S_DIV_ISSUE, S_DIV_WAIT, S_LOOP_INIT,
        S_COLSET, S_COLOW, S_ROWSET, S_ROWOH, S_AREA, S_MUL, S_WB,
        S_RD_CALC, S_RD_DIV, S_RD_WAIT, S_RD_OUT
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [1:0]        sel_reg;
    logic [2:0]        k_reg;
    logic [47:0]       sum_reg;
    logic              out_valid_reg;
    logic [31:0]       dens_reg;
    logic [40:0]       ovf_out_reg;
    logic [47:0]       tot_out_reg;

    // Configuration registers
    logic [8:0]          across_reg;
    logic [8:0]          down_reg;
    logic [23:0]         bw_reg;
    logic [23:0]         bh_reg;
    logic signed [31:0]  left_reg;
    logic signed [31:0]  bottom_reg;

    // Item and datapath registers
    logic signed [31:0]  cx_reg;
    logic signed [31:0]  cy_reg;
    logic [23:0]         cw_reg;
    logic [23:0]         ch_reg;
    logic [23:0]         scale_reg;
    logic                filler_reg;
    logic                macro_reg;
    logic signed [CW-1:0] lx_reg;
    logic signed [CW-1:0] ux_reg;
    logic signed [CW-1:0] ly_reg;
    logic signed [CW-1:0] uy_reg;
    logic [XW-1:0]       i0_reg;
    logic [XW-1:0]       i1_reg;
    logic [YW-1:0]       j0_reg;
    logic [YW-1:0]       j1_reg;
    logic [XW-1:0]       i_reg;
    logic [YW-1:0]       j_reg;
    logic signed [CW-1:0] bl_reg;
    logic signed [CW-1:0] bb_reg;
    logic [23:0]         ow_reg;
    logic [23:0]         oh_reg;
    logic [IW-1:0]       idx_reg;
    logic [47:0]         area_reg;
    logic [39:0]         b_reg;
    logic [87:0]         prod_reg;
    logic [95:0]         old_acc_reg;
    logic [49:0]         total_reg;
    logic [39:0]         cap_reg;
    logic [40:0]         ovf_reg;
    logic                rd_oor_reg;

    // Combinational signals
    pdba_pkg::cmd_t      cmd;
    logic                in_fire;
    logic                cfg_wr;
    logic [XW-1:0]       cols_eff;
    logic [YW-1:0]       rows_eff;
    logic [23:0]         bw_eff;
    logic [23:0]         bh_eff;
    logic signed [CW-1:0] left_ext;
    logic signed [CW-1:0] bottom_ext;
    logic                bin_ok;
    logic                idx_ok;
    logic signed [CW-1:0] geo_a;
    logic [23:0]         geo_d;
    logic                geo_pos;
    logic [34:0]         geo_round;
    logic [34:0]         geo_lim;
    logic [34:0]         geo_bound;
    logic [IW-1:0]       idx_next;
    logic signed [CW-1:0] bl_next;
    logic signed [CW-1:0] bb_next;
    logic [7:0]          b_chunk;
    logic [55:0]         pp;
    logic [47:0]         contrib;
    logic [47:0]         acc_old;
    logic [47:0]         acc_new;
    logic [48:0]         used;
    logic [48:0]         used_diff;
    logic [40:0]         ovf_next;
    logic [31:0]         dens_next;
    logic                out_free;

    // Memories and divider
    logic                acc_we;
    logic [AW-1:0]       acc_waddr;
    logic [95:0]         acc_wdata;
    logic                acc_re;
    logic [AW-1:0]       acc_raddr;
    logic [95:0]         acc_q;
    logic                prm_we;
    logic [95:0]         prm_q;
    pdba_pkg::div_req_t  div_req;
    logic [pdba_pkg::DVD_W-1:0] div_dvd;
    logic [pdba_pkg::DVS_W-1:0] div_dvs;
    logic                div_done;
    logic [pdba_pkg::DVD_W-1:0] div_q;
    logic [pdba_pkg::DVS_W-1:0] div_r;

    assign cmd      = pdba_pkg::cmd_t'(command);
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !out_valid_reg || out_ready;

    // Effective grid: clamp counts, treat zero size as one
    assign cols_eff = (across_reg == 9'd0) ? XW'(1) :
                      ((32'(across_reg) > MAX_BINS_X) ? XW'(MAX_BINS_X) : XW'(across_reg));
    assign rows_eff = (down_reg == 9'd0) ? YW'(1) :
                      ((32'(down_reg) > MAX_BINS_Y) ? YW'(MAX_BINS_Y) : YW'(down_reg));
    assign bw_eff     = (bw_reg == 24'd0) ? 24'd1 : bw_reg;
    assign bh_eff     = (bh_reg == 24'd0) ? 24'd1 : bh_reg;
    assign left_ext   = {{(CW-32){left_reg[31]}}, left_reg};
    assign bottom_ext = {{(CW-32){bottom_reg[31]}}, bottom_reg};

    assign bin_ok = 32'(bin_index) < BIN_COUNT;
    assign idx_ok = 32'(idx_reg) < BIN_COUNT;

    // Register read mux
    always_comb
    begin
        unique case (paddr[4:2])
            pdba_pkg::REG_BINS_ACROSS: prdata = {23'd0, across_reg};
            pdba_pkg::REG_BINS_DOWN:   prdata = {23'd0, down_reg};
            pdba_pkg::REG_BIN_WIDTH:   prdata = {8'd0, bw_reg};
            pdba_pkg::REG_BIN_HEIGHT:  prdata = {8'd0, bh_reg};
            pdba_pkg::REG_CORE_LEFT:   prdata = left_reg;
            pdba_pkg::REG_CORE_BOTTOM: prdata = bottom_reg;
            default:                   prdata = 32'd0;
        endcase
    end

    // Select the edge offset and bin pitch for the current bound divide
    always_comb
    begin
        case (sel_reg)
            2'd0:    geo_a = lx_reg - left_ext;
            2'd1:    geo_a = ux_reg - left_ext;
            2'd2:    geo_a = ly_reg - bottom_ext;
            default: geo_a = uy_reg - bottom_ext;
        endcase
        geo_d   = sel_reg[1] ? bh_eff : bw_eff;
        geo_pos = !geo_a[CW-1] && (geo_a != '0);
    end

    // Round the upper bounds up, clamp every bound to the grid
    assign geo_round = sel_reg[0] ? (35'(div_q[33:0]) + 35'(|div_r)) : 35'(div_q[33:0]);
    assign geo_lim   = sel_reg[1] ? 35'(rows_eff) : 35'(cols_eff);
    assign geo_bound = (geo_round > geo_lim) ? geo_lim : geo_round;

    // Bin origin and linear index for the current column and row
    assign bl_next  = left_ext + signed'(CW'(i_reg) * CW'(bw_eff));
    assign bb_next  = bottom_ext + signed'(CW'(j_reg) * CW'(bh_eff));
    assign idx_next = IW'(IW'(j_reg) * IW'(cols_eff)) + IW'(i_reg);

    // Partial product for one 8-bit slice of the scale factor
    assign b_chunk = b_reg[{k_reg, 3'b000} +: 8];
    assign pp      = {8'd0, area_reg} * {48'd0, b_chunk};

    // Contribution and saturating accumulate
    assign contrib = (|prod_reg[87:79]) ? pdba_pkg::CAP48 : prod_reg[78:31];
    assign acc_old = filler_reg ? old_acc_reg[47:0] : old_acc_reg[95:48];
    assign acc_new = pdba_pkg::add_sat48(acc_old, contrib);

    // Overflow of a bin being read
    assign used      = {1'b0, acc_q[95:48]} + 49'(prm_q[95:56]);
    assign used_diff = used - 49'(prm_q[55:16]);
    always_comb
    begin
        if (used <= 49'(prm_q[55:16]))
            ovf_next = 41'd0;
        else if (|used_diff[48:41])
            ovf_next = pdba_pkg::CAP41;
        else
            ovf_next = used_diff[40:0];
    end

    // Density from the divider, saturating; zero for an out-of-range bin
    assign dens_next = rd_oor_reg ? 32'd0 :
                       ((cap_reg == 40'd0 || |div_q[65:32]) ? pdba_pkg::CAP32 : div_q[31:0]);

    // Divider request
    always_comb
    begin
        div_req.start = (state_reg == S_DIV_ISSUE && geo_pos) || (state_reg == S_RD_DIV);
        div_req.steps = (state_reg == S_RD_DIV) ? pdba_pkg::STEPS_READ : pdba_pkg::STEPS_GEOM;
        div_dvd       = (state_reg == S_RD_DIV) ? {total_reg, 16'd0} : {geo_a[33:0], 32'd0};
        div_dvs       = (state_reg == S_RD_DIV) ? cap_reg : {16'd0, geo_d};
    end

    // Accumulator and parameter RAM access: clear sweep, bin write-back, reads, parameter load
    assign acc_we    = (state_reg == S_CLEAR) || (state_reg == S_WB);
    assign acc_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : idx_reg[AW-1:0];
    assign acc_wdata = (state_reg == S_CLEAR) ? 96'd0 :
                       (filler_reg ? {old_acc_reg[95:48], acc_new} : {acc_new, old_acc_reg[47:0]});
    assign acc_re    = (in_fire && cmd == pdba_pkg::CMD_READ) || (state_reg == S_ROWOH && idx_ok);
    assign acc_raddr = (state_reg == S_ROWOH) ? idx_reg[AW-1:0] : AW'(bin_index);
    assign prm_we    = in_fire && cmd == pdba_pkg::CMD_LOAD && bin_ok;

    pdba_ram #(
        .WIDTH (96),
        .DEPTH (BIN_COUNT)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_q)
    );

    pdba_ram #(
        .WIDTH (96),
        .DEPTH (BIN_COUNT)
    ) u_prm_ram (
        .clk   (clk),
        .we    (prm_we),
        .waddr (AW'(bin_index)),
        .wdata ({blocked_area, capacity_area, target_density}),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (prm_q)
    );

    pdba_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Sequencer state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            sel_reg       <= 2'd0;
            k_reg         <= 3'd0;
            sum_reg       <= 48'd0;
            out_valid_reg <= 1'b0;
            dens_reg      <= 32'd0;
            ovf_out_reg   <= 41'd0;
            tot_out_reg   <= 48'd0;
            across_reg    <= 9'd1;
            down_reg      <= 9'd1;
            bw_reg        <= 24'd1;
            bh_reg        <= 24'd1;
            left_reg      <= 32'sd0;
            bottom_reg    <= 32'sd0;
        end
        else
        begin
            // Configuration writes
            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    pdba_pkg::REG_BINS_ACROSS: across_reg <= pwdata[8:0];
                    pdba_pkg::REG_BINS_DOWN:   down_reg   <= pwdata[8:0];
                    pdba_pkg::REG_BIN_WIDTH:   bw_reg     <= pwdata[23:0];
                    pdba_pkg::REG_BIN_HEIGHT:  bh_reg     <= pwdata[23:0];
                    pdba_pkg::REG_CORE_LEFT:   left_reg   <= pwdata;
                    pdba_pkg::REG_CORE_BOTTOM: bottom_reg <= pwdata;
                    default: ;
                endcase
            end

            // Drop the result word once taken, unless a new one replaces it
            if (out_valid_reg && out_ready && state_reg != S_RD_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(BIN_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (cmd)
                            pdba_pkg::CMD_CLEAR:
                            begin
                                sum_reg     <= 48'd0;
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            pdba_pkg::CMD_LOAD: state_reg <= S_IDLE;
                            pdba_pkg::CMD_ADD:  state_reg <= S_PREP;
                            pdba_pkg::CMD_READ: state_reg <= bin_ok ? S_RD_CALC : S_RD_OUT;
                            default:            state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_PREP:
                begin
                    sel_reg   <= 2'd0;
                    state_reg <= S_DIV_ISSUE;
                end
                S_DIV_ISSUE:
                begin
                    if (geo_pos)
                        state_reg <= S_DIV_WAIT;
                    else
                    begin
                        sel_reg   <= sel_reg + 1'b1;
                        state_reg <= (sel_reg == 2'd3) ? S_LOOP_INIT : S_DIV_ISSUE;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        sel_reg   <= sel_reg + 1'b1;
                        state_reg <= (sel_reg == 2'd3) ? S_LOOP_INIT : S_DIV_ISSUE;
                    end
                end
                S_LOOP_INIT: state_reg <= S_COLSET;
                S_COLSET:    state_reg <= (i_reg >= i1_reg) ? S_IDLE : S_COLOW;
                S_COLOW:     state_reg <= S_ROWSET;
                S_ROWSET:    state_reg <= (j_reg >= j1_reg) ? S_COLSET : S_ROWOH;
                S_ROWOH:     state_reg <= idx_ok ? S_AREA : S_ROWSET;
                S_AREA:
                begin
                    k_reg     <= 3'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd4)
                        state_reg <= S_WB;
                end
                S_WB:        state_reg <= S_ROWSET;
                S_RD_CALC:   state_reg <= S_RD_DIV;
                S_RD_DIV:
                begin
                    sum_reg   <= pdba_pkg::add_sat48(sum_reg, {7'd0, ovf_reg});
                    state_reg <= S_RD_WAIT;
                end
                S_RD_WAIT:
                begin
                    if (div_done)
                        state_reg <= S_RD_OUT;
                end
                S_RD_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        dens_reg      <= dens_next;
                        ovf_out_reg   <= rd_oor_reg ? 41'd0 : ovf_reg;
                        tot_out_reg   <= sum_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        // Capture the word
        if (in_fire)
        begin
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            cw_reg     <= cell_width;
            ch_reg     <= cell_height;
            scale_reg  <= density_scale;
            filler_reg <= is_filler;
            macro_reg  <= is_macro;
            rd_oor_reg <= !bin_ok;
        end

        unique case (state_reg)
            S_PREP:
            begin
                lx_reg <= {{(CW-32){cx_reg[31]}}, cx_reg} - CW'(cw_reg[23:1]);
                ux_reg <= {{(CW-32){cx_reg[31]}}, cx_reg} + CW'(cw_reg[23:1]);
                ly_reg <= {{(CW-32){cy_reg[31]}}, cy_reg} - CW'(ch_reg[23:1]);
                uy_reg <= {{(CW-32){cy_reg[31]}}, cy_reg} + CW'(ch_reg[23:1]);
            end
            S_DIV_ISSUE:
            begin
                // Non-positive edge offset bounds at zero without a divide
                if (!geo_pos)
                begin
                    case (sel_reg)
                        2'd0:    i0_reg <= '0;
                        2'd1:    i1_reg <= '0;
                        2'd2:    j0_reg <= '0;
                        default: j1_reg <= '0;
                    endcase
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        2'd0:    i0_reg <= XW'(geo_bound);
                        2'd1:    i1_reg <= XW'(geo_bound);
                        2'd2:    j0_reg <= YW'(geo_bound);
                        default: j1_reg <= YW'(geo_bound);
                    endcase
                end
            end
            S_LOOP_INIT: i_reg <= i0_reg;
            S_COLSET:
            begin
                bl_reg <= bl_next;
                j_reg  <= j0_reg;
            end
            S_COLOW: ow_reg <= pdba_pkg::overlap(lx_reg, ux_reg, bl_reg, bl_reg + CW'(bw_eff));
            S_ROWSET:
            begin
                if (j_reg >= j1_reg)
                    i_reg <= i_reg + 1'b1;
                bb_reg  <= bb_next;
                idx_reg <= idx_next;
            end
            S_ROWOH:
            begin
                oh_reg <= pdba_pkg::overlap(ly_reg, uy_reg, bb_reg, bb_reg + CW'(bh_eff));
                if (!idx_ok)
                    j_reg <= j_reg + 1'b1;
            end
            S_AREA:
            begin
                // Non-filler macros scale by target; others by 2^15 to share the shift
                area_reg    <= {24'd0, ow_reg} * {24'd0, oh_reg};
                old_acc_reg <= acc_q;
                b_reg       <= (macro_reg && !filler_reg) ?
                               ({16'd0, scale_reg} * {24'd0, prm_q[15:0]}) :
                               {1'b0, scale_reg, 15'd0};
                prod_reg    <= 88'd0;
            end
            S_MUL: prod_reg <= prod_reg + ({32'd0, pp} << {k_reg, 3'b000});
            S_WB:  j_reg <= j_reg + 1'b1;
            S_RD_CALC:
            begin
                total_reg <= 50'(prm_q[95:56]) + 50'(acc_q[95:48]) + 50'(acc_q[47:0]);
                cap_reg   <= prm_q[55:16];
                ovf_reg   <= ovf_next;
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign bin_density    = dens_reg;
    assign overflow_area  = ovf_out_reg;
    assign overflow_total = tot_out_reg;

`include "placement_density_bin_accumulator_core_defines.svh"

    `PDBA_ASSERT_IMPL(a_div_done_expected, div_done, (state_reg == S_DIV_WAIT) || (state_reg == S_RD_WAIT))
    `PDBA_ASSERT_NEXT(a_sum_no_decrease, !(in_fire && cmd == pdba_pkg::CMD_CLEAR), sum_reg >= $past(sum_reg))
    `PDBA_ASSERT_IMPL(a_result_from_read, $rose(out_valid_reg), $past(state_reg) == S_RD_OUT)

endmodule

`default_nettype wire
